[rtl/core/gca_pkg.sv]
// Shared constants, register indexes and controller/datapath interface types
// for the guided chunk allocator. No dependencies.
`default_nettype none

package gca_pkg;

  localparam int SIZE_BITS  = 40;
  localparam int COUNT_BITS = 32;
  localparam int SHARE_BITS = 17;
  localparam int MULT_BITS  = 16;
  localparam int K_BITS     = 12;
  localparam int FRAC_BITS  = 8;

  localparam int MIN_BITS  = 2 * MULT_BITS;
  localparam int PROD_BITS = SIZE_BITS + SHARE_BITS;
  localparam int PKG_BITS  = PROD_BITS - FRAC_BITS;
  localparam int CMP_BITS  = (PKG_BITS > MIN_BITS) ? PKG_BITS : MIN_BITS;

  // serial divider retires two quotient bits per cycle
  localparam int DIV_STEPS    = (PKG_BITS + 1) / 2;
  localparam int DIV_PAD      = 2 * DIV_STEPS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (SIZE_BITS > SHARE_BITS) ? SIZE_BITS : SHARE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_SIZE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_MULTIPLE = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CPU_SHARE     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ACC_SHARE     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_K_DIVISOR     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_MULT_CPU  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_MULT_ACC  = 3'd6;

  typedef enum logic [2:0] {
    PKG_HOLD,
    PKG_REM,
    PKG_KQUO,
    PKG_MIN,
    PKG_MROUND
  } gca_pkg_src_e;

  typedef struct packed {
    logic         capture;
    logic         load_rem;
    logic         load_prod;
    logic         div_start;
    logic         div_sel_mult;
    gca_pkg_src_e pkg_src;
    logic         load_out;
  } gca_cmd_t;

  typedef struct packed {
    logic div_done;
    logic k_zero;
    logic below_min;
  } gca_sts_t;

endpackage

`default_nettype wire

[rtl/core/gca_div.sv]
// Iterative restoring divider, two quotient bits per cycle.
// Depends on gca_pkg for operand widths and step count.
`default_nettype none

module gca_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [gca_pkg::PKG_BITS-1:0]  dividend_i,
  input  wire logic [gca_pkg::MULT_BITS-1:0] divisor_i,
  output logic                               done_o,
  output logic [gca_pkg::PKG_BITS-1:0]       quotient_o,
  output logic [gca_pkg::MULT_BITS-1:0]      remainder_o
);

  logic [gca_pkg::DIV_PAD-1:0]      quo_q, quo_d;
  logic [gca_pkg::MULT_BITS-1:0]    rem_q, rem_d;
  logic [gca_pkg::MULT_BITS-1:0]    dvs_q;
  logic [gca_pkg::DIV_CNT_BITS-1:0] cnt_q;
  logic                             done_q;

  always_comb begin
    logic [gca_pkg::MULT_BITS:0]   t;
    logic [gca_pkg::MULT_BITS-1:0] r;
    logic [gca_pkg::DIV_PAD-1:0]   q;
    r = rem_q;
    q = quo_q;
    t = '0;
    for (int i = 0; i < 2; i++) begin
      t = {r, q[gca_pkg::DIV_PAD-1]};
      q = {q[gca_pkg::DIV_PAD-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t    = t - {1'b0, dvs_q};
        q[0] = 1'b1;
      end
      r = t[gca_pkg::MULT_BITS-1:0];
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= gca_pkg::DIV_CNT_BITS'(gca_pkg::DIV_STEPS);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - gca_pkg::DIV_CNT_BITS'(1);
        if (cnt_q == gca_pkg::DIV_CNT_BITS'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= gca_pkg::DIV_PAD'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q[gca_pkg::PKG_BITS-1:0];
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[rtl/core/gca_datapath.sv]
// Datapath: configuration registers, allocation state, remainder, share
// product, package sizing and result registers. Uses gca_pkg and gca_div.
`default_nettype none

module gca_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [gca_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [gca_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                              requester_is_acc_i,
  input  wire gca_pkg::gca_cmd_t                 cmd_i,
  output gca_pkg::gca_sts_t                      sts_o,
  output logic                                   granted_o,
  output logic [gca_pkg::SIZE_BITS-1:0]          chunk_offset_o,
  output logic [gca_pkg::SIZE_BITS-1:0]          chunk_size_o,
  output logic [gca_pkg::COUNT_BITS-1:0]         package_id_o,
  output logic [gca_pkg::COUNT_BITS-1:0]         device_package_id_o,
  output logic                                   final_chunk_o
);

  // configuration
  logic [gca_pkg::SIZE_BITS-1:0]  total_size_q;
  logic [gca_pkg::MULT_BITS-1:0]  size_multiple_q;
  logic [gca_pkg::SHARE_BITS-1:0] cpu_share_q;
  logic [gca_pkg::SHARE_BITS-1:0] acc_share_q;
  logic [gca_pkg::K_BITS-1:0]     k_divisor_q;
  logic [gca_pkg::MULT_BITS-1:0]  min_mult_cpu_q;
  logic [gca_pkg::MULT_BITS-1:0]  min_mult_acc_q;

  // allocation state
  logic [gca_pkg::SIZE_BITS-1:0]  work_assigned_q;
  logic [gca_pkg::COUNT_BITS-1:0] global_cnt_q;
  logic [gca_pkg::COUNT_BITS-1:0] cpu_cnt_q;
  logic [gca_pkg::COUNT_BITS-1:0] acc_cnt_q;

  // per-request working registers
  logic                           acc_q;
  logic [gca_pkg::SIZE_BITS-1:0]  rem_q;
  logic [gca_pkg::MIN_BITS-1:0]   min_pkg_q;
  logic [gca_pkg::PROD_BITS-1:0]  prod_q;
  logic [gca_pkg::PKG_BITS-1:0]   pkg_q;

  logic [gca_pkg::MULT_BITS-1:0]  mult_eff;
  logic [gca_pkg::MULT_BITS-1:0]  min_mult_sel;
  logic [gca_pkg::SHARE_BITS-1:0] share_sel;
  logic [gca_pkg::PKG_BITS-1:0]   div_dividend;
  logic [gca_pkg::MULT_BITS-1:0]  div_divisor;
  logic                           div_done;
  logic [gca_pkg::PKG_BITS-1:0]   div_quo;
  logic [gca_pkg::MULT_BITS-1:0]  div_rem;

  logic                           rem_zero;
  logic                           is_final;
  logic [gca_pkg::SIZE_BITS-1:0]  clipped;
  logic [gca_pkg::SIZE_BITS-1:0]  size_fin;
  logic [gca_pkg::CMP_BITS-1:0]   rem_cmp;
  logic [gca_pkg::CMP_BITS-1:0]   min_cmp;
  logic [gca_pkg::CMP_BITS-1:0]   pkg_cmp;

  assign mult_eff     = (size_multiple_q == '0) ? gca_pkg::MULT_BITS'(1) : size_multiple_q;
  assign min_mult_sel = acc_q ? min_mult_acc_q : min_mult_cpu_q;
  assign share_sel    = acc_q ? acc_share_q : cpu_share_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_size_q    <= '0;
      size_multiple_q <= gca_pkg::MULT_BITS'(1);
      cpu_share_q     <= gca_pkg::SHARE_BITS'(32768);
      acc_share_q     <= gca_pkg::SHARE_BITS'(32768);
      k_divisor_q     <= gca_pkg::K_BITS'(512);
      min_mult_cpu_q  <= gca_pkg::MULT_BITS'(1);
      min_mult_acc_q  <= gca_pkg::MULT_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gca_pkg::CFG_TOTAL_SIZE:    total_size_q    <= cfg_data_i[gca_pkg::SIZE_BITS-1:0];
        gca_pkg::CFG_SIZE_MULTIPLE: size_multiple_q <= cfg_data_i[gca_pkg::MULT_BITS-1:0];
        gca_pkg::CFG_CPU_SHARE:     cpu_share_q     <= cfg_data_i[gca_pkg::SHARE_BITS-1:0];
        gca_pkg::CFG_ACC_SHARE:     acc_share_q     <= cfg_data_i[gca_pkg::SHARE_BITS-1:0];
        gca_pkg::CFG_K_DIVISOR:     k_divisor_q     <= cfg_data_i[gca_pkg::K_BITS-1:0];
        gca_pkg::CFG_MIN_MULT_CPU:  min_mult_cpu_q  <= cfg_data_i[gca_pkg::MULT_BITS-1:0];
        gca_pkg::CFG_MIN_MULT_ACC:  min_mult_acc_q  <= cfg_data_i[gca_pkg::MULT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // dividing by K*256 is the same as dropping 8 product bits and dividing by K
  assign div_dividend = cmd_i.div_sel_mult ? pkg_q
                                           : prod_q[gca_pkg::PROD_BITS-1:gca_pkg::FRAC_BITS];
  assign div_divisor  = cmd_i.div_sel_mult ? mult_eff
                      : {{(gca_pkg::MULT_BITS-gca_pkg::K_BITS){1'b0}}, k_divisor_q};

  gca_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      acc_q <= requester_is_acc_i;
    end
    if (cmd_i.load_rem) begin
      rem_q     <= (work_assigned_q < total_size_q) ? (total_size_q - work_assigned_q) : '0;
      min_pkg_q <= gca_pkg::MIN_BITS'(mult_eff) * gca_pkg::MIN_BITS'(min_mult_sel);
    end
    if (cmd_i.load_prod) begin
      prod_q <= gca_pkg::PROD_BITS'(rem_q) * gca_pkg::PROD_BITS'(share_sel);
    end
    case (cmd_i.pkg_src)
      gca_pkg::PKG_REM:    pkg_q <= {{(gca_pkg::PKG_BITS-gca_pkg::SIZE_BITS){1'b0}}, rem_q};
      gca_pkg::PKG_KQUO:   pkg_q <= div_quo;
      gca_pkg::PKG_MIN:    pkg_q <= gca_pkg::PKG_BITS'(min_pkg_q);
      // round down to the size multiple: subtract the division remainder
      gca_pkg::PKG_MROUND: pkg_q <= pkg_q - gca_pkg::PKG_BITS'(div_rem);
      default: ;
    endcase
  end

  assign rem_cmp = gca_pkg::CMP_BITS'(rem_q);
  assign min_cmp = gca_pkg::CMP_BITS'(min_pkg_q);
  assign pkg_cmp = gca_pkg::CMP_BITS'(pkg_q);

  assign sts_o.div_done  = div_done;
  assign sts_o.k_zero    = (k_divisor_q == '0);
  assign sts_o.below_min = (pkg_cmp < min_cmp);

  assign rem_zero = (rem_q == '0);
  assign is_final = (rem_cmp < min_cmp);
  assign clipped  = (pkg_cmp >= rem_cmp) ? rem_q : pkg_q[gca_pkg::SIZE_BITS-1:0];
  assign size_fin = is_final ? rem_q : clipped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_assigned_q <= '0;
      global_cnt_q    <= '0;
      cpu_cnt_q       <= '0;
      acc_cnt_q       <= '0;
    end else if (cmd_i.load_out && !rem_zero) begin
      work_assigned_q <= work_assigned_q + size_fin;
      global_cnt_q    <= global_cnt_q + gca_pkg::COUNT_BITS'(1);
      if (acc_q) begin
        acc_cnt_q <= acc_cnt_q + gca_pkg::COUNT_BITS'(1);
      end else begin
        cpu_cnt_q <= cpu_cnt_q + gca_pkg::COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (rem_zero) begin
        granted_o           <= 1'b0;
        chunk_offset_o      <= '0;
        chunk_size_o        <= '0;
        package_id_o        <= '0;
        device_package_id_o <= '0;
        final_chunk_o       <= 1'b0;
      end else begin
        granted_o           <= 1'b1;
        chunk_offset_o      <= work_assigned_q;
        chunk_size_o        <= size_fin;
        package_id_o        <= global_cnt_q;
        device_package_id_o <= acc_q ? acc_cnt_q : cpu_cnt_q;
        final_chunk_o       <= is_final;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/gca_ctrl.sv]
// Controller state machine: sequences remainder, multiply, the two divider
// passes and the result register. Uses gca_pkg command and status types.
`default_nettype none

module gca_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire gca_pkg::gca_sts_t sts_i,
  output gca_pkg::gca_cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REM   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_KDIV  = 3'd3;
  localparam logic [2:0] ST_KWAIT = 3'd4;
  localparam logic [2:0] ST_MDIV  = 3'd5;
  localparam logic [2:0] ST_MWAIT = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.pkg_src = gca_pkg::PKG_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_REM;
        end
      end
      ST_REM: begin
        cmd_o.load_rem = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.load_prod = 1'b1;
        state_d = ST_KDIV;
      end
      ST_KDIV: begin
        if (sts_i.k_zero) begin
          cmd_o.pkg_src = gca_pkg::PKG_REM;
          state_d = ST_MDIV;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_KWAIT;
        end
      end
      ST_KWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.pkg_src = gca_pkg::PKG_KQUO;
          state_d = ST_MDIV;
        end
      end
      ST_MDIV: begin
        if (sts_i.below_min) begin
          cmd_o.pkg_src = gca_pkg::PKG_MIN;
          state_d = ST_DONE;
        end else begin
          cmd_o.div_start    = 1'b1;
          cmd_o.div_sel_mult = 1'b1;
          state_d = ST_MWAIT;
        end
      end
      ST_MWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.pkg_src = gca_pkg::PKG_MROUND;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_REM))
    else $error("accepted request did not start the sequence");

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_KWAIT || state_q == ST_MWAIT))
    else $error("divider finished outside a wait state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while stalled");

  a_single_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !cmd_o.div_start)
    else $error("divider started twice in a row");
`endif

endmodule

`default_nettype wire

[rtl/core/guided_chunk_allocator_core.sv]
// Guided chunk allocator: one work package per request, one request at a time.
// The general case runs two passes of the shared serial divider at two quotient
// bits a cycle, first by K and then by the size multiple; the K pass is skipped
// when K is zero and the multiple pass when the package is raised to the minimum.
// A new request is taken the cycle after the result is loaded.
// Reset (async, active low) restores register defaults and clears all counters.
`default_nettype none

module guided_chunk_allocator_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [gca_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [gca_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              requester_is_acc_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   granted_o,
  output logic [gca_pkg::SIZE_BITS-1:0]          chunk_offset_o,
  output logic [gca_pkg::SIZE_BITS-1:0]          chunk_size_o,
  output logic [gca_pkg::COUNT_BITS-1:0]         package_id_o,
  output logic [gca_pkg::COUNT_BITS-1:0]         device_package_id_o,
  output logic                                   final_chunk_o
);

  gca_pkg::gca_cmd_t cmd;
  gca_pkg::gca_sts_t sts;

  // writes must arrive only while idle (the block does not enforce this); the port never back-pressures
  assign cfg_ready_o = 1'b1;

  gca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gca_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .requester_is_acc_i  (requester_is_acc_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .granted_o           (granted_o),
    .chunk_offset_o      (chunk_offset_o),
    .chunk_size_o        (chunk_size_o),
    .package_id_o        (package_id_o),
    .device_package_id_o (device_package_id_o),
    .final_chunk_o       (final_chunk_o)
  );

endmodule

`default_nettype wire

[dv/tb_guided_chunk_allocator_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for guided_chunk_allocator_core: random request traffic
// under bursty sender and stalling receiver, checked against a built-in package predictor.
// Depends on gca_pkg and the core RTL.

module tb_guided_chunk_allocator_core;

  localparam int LIMIT = 400000;

  typedef logic [gca_pkg::CFG_DATA_BITS-1:0] cfg_word_t;

  typedef struct packed {
    logic                           granted;
    logic [gca_pkg::SIZE_BITS-1:0]  offset;
    logic [gca_pkg::SIZE_BITS-1:0]  size;
    logic [gca_pkg::COUNT_BITS-1:0] pkg_id;
    logic [gca_pkg::COUNT_BITS-1:0] dev_id;
    logic                           final_chunk;
  } grant_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [gca_pkg::CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [gca_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              requester_is_acc_i = 1'b0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              granted_o;
  logic [gca_pkg::SIZE_BITS-1:0]     chunk_offset_o;
  logic [gca_pkg::SIZE_BITS-1:0]     chunk_size_o;
  logic [gca_pkg::COUNT_BITS-1:0]    package_id_o;
  logic [gca_pkg::COUNT_BITS-1:0]    device_package_id_o;
  logic                              final_chunk_o;

  // predictor copy of registers and allocation state
  logic [gca_pkg::SIZE_BITS-1:0]  tot = '0;
  logic [gca_pkg::MULT_BITS-1:0]  mult = 16'd1;
  logic [gca_pkg::SHARE_BITS-1:0] cpu_share = 17'd32768;
  logic [gca_pkg::SHARE_BITS-1:0] acc_share = 17'd32768;
  logic [gca_pkg::K_BITS-1:0]     kdiv = 12'd512;
  logic [gca_pkg::MULT_BITS-1:0]  min_cpu = 16'd1;
  logic [gca_pkg::MULT_BITS-1:0]  min_acc = 16'd1;
  logic [gca_pkg::SIZE_BITS-1:0]  assigned = '0;
  logic [gca_pkg::COUNT_BITS-1:0] global_cnt = '0;
  logic [gca_pkg::COUNT_BITS-1:0] cpu_cnt = '0;
  logic [gca_pkg::COUNT_BITS-1:0] acc_cnt = '0;

  logic   request_q[$];
  grant_t grants_q[$];
  logic   req_taken = 1'b0;
  int     errors = 0;
  int     results_seen = 0;
  int     cycles = 0;

  guided_chunk_allocator_core DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .requester_is_acc_i  (requester_is_acc_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .granted_o           (granted_o),
    .chunk_offset_o      (chunk_offset_o),
    .chunk_size_o        (chunk_size_o),
    .package_id_o        (package_id_o),
    .device_package_id_o (device_package_id_o),
    .final_chunk_o       (final_chunk_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Computes the package for one request and advances the allocation state.
  function automatic grant_t next_grant(input logic acc);
    logic [63:0] unit, min_pkg, remain, pkg, share, kd;
    grant_t g;
    g = '0;
    unit = 64'(mult);
    if (unit == '0) unit = 64'd1;
    min_pkg = unit * 64'(acc ? min_acc : min_cpu);
    remain = (assigned < tot) ? 64'(tot - assigned) : 64'd0;
    if (remain == '0) return g;
    share = 64'(acc ? acc_share : cpu_share);
    if (remain >= min_pkg) begin
      if (kdiv == '0) begin
        pkg = remain;
      end else begin
        kd = 64'(kdiv);
        // at most 57 bits, so no saturation is needed
        pkg = (remain * share) / (kd << gca_pkg::FRAC_BITS);
      end
      if (pkg < min_pkg) pkg = min_pkg;
      else pkg = (pkg / unit) * unit;
      if (pkg > remain) pkg = remain;
    end else begin
      pkg = remain;
      g.final_chunk = 1'b1;
    end
    g.granted = 1'b1;
    g.offset  = assigned;
    g.size    = pkg[gca_pkg::SIZE_BITS-1:0];
    g.pkg_id  = global_cnt;
    g.dev_id  = acc ? acc_cnt : cpu_cnt;
    assigned   = assigned + pkg[gca_pkg::SIZE_BITS-1:0];
    global_cnt = global_cnt + gca_pkg::COUNT_BITS'(1);
    if (acc) acc_cnt = acc_cnt + gca_pkg::COUNT_BITS'(1);
    else cpu_cnt = cpu_cnt + gca_pkg::COUNT_BITS'(1);
    return g;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
    end
  endtask

  // Monitor: predicts on every request transfer, checks every result transfer.
  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        grants_q.push_back(next_grant(requester_is_acc_i));
        req_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (grants_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          errors++;
        end else begin
          want = grants_q.pop_front();
          check_field("granted", 64'(want.granted), 64'(granted_o));
          check_field("chunk_offset", 64'(want.offset), 64'(chunk_offset_o));
          check_field("chunk_size", 64'(want.size), 64'(chunk_size_o));
          check_field("package_id", 64'(want.pkg_id), 64'(package_id_o));
          check_field("device_package_id", 64'(want.dev_id), 64'(device_package_id_o));
          check_field("final_chunk", 64'(want.final_chunk), 64'(final_chunk_o));
        end
      end
    end
  end

  // Driver: bursts of requests separated by random gaps; holds while stalled.
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (!(in_valid_i && !req_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        in_valid_i <= 1'b1;
        requester_is_acc_i <= request_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Receiver: switches among random stall patterns; long hold-offs
  // at intervals of results so the core backs up into its request port.
  int hold_left = 0;
  int next_hold = 40;
  int rx_tick = 0;
  int rx_mode = 0;

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (results_seen >= next_hold) begin
      next_hold += 210;
      hold_left = 299;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
      rx_tick++;
      case (rx_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= 1'($urandom_range(0, 1));
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (rx_tick % 5) < 2;
      endcase
    end
  end

  task automatic set_reg(input logic [gca_pkg::CFG_IDX_BITS-1:0] idx,
                         input cfg_word_t val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gca_pkg::CFG_TOTAL_SIZE:    tot = val[gca_pkg::SIZE_BITS-1:0];
      gca_pkg::CFG_SIZE_MULTIPLE: mult = val[gca_pkg::MULT_BITS-1:0];
      gca_pkg::CFG_CPU_SHARE:     cpu_share = val[gca_pkg::SHARE_BITS-1:0];
      gca_pkg::CFG_ACC_SHARE:     acc_share = val[gca_pkg::SHARE_BITS-1:0];
      gca_pkg::CFG_K_DIVISOR:     kdiv = val[gca_pkg::K_BITS-1:0];
      gca_pkg::CFG_MIN_MULT_CPU:  min_cpu = val[gca_pkg::MULT_BITS-1:0];
      gca_pkg::CFG_MIN_MULT_ACC:  min_acc = val[gca_pkg::MULT_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid_i || grants_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic queue_requests(input int cnt, input int acc_pct);
    repeat (cnt) request_q.push_back($urandom_range(0, 99) < acc_pct);
  endtask

  function automatic logic [15:0] pick_mult(input int top);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      7: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, top));
    endcase
  endfunction

  function automatic logic [16:0] pick_share();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    logic [63:0] r;
    logic [gca_pkg::SIZE_BITS-1:0] t;
    logic [11:0] pat;
    int sent;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // defaults after reset: total is zero, so nothing is left
    request_q.push_back(1'b0);
    request_q.push_back(1'b1);
    wait_idle();

    // rounding to the size multiple, raise to minimum, final remainder
    set_reg(gca_pkg::CFG_TOTAL_SIZE, cfg_word_t'(1000));
    set_reg(gca_pkg::CFG_SIZE_MULTIPLE, cfg_word_t'(4));
    set_reg(gca_pkg::CFG_MIN_MULT_CPU, cfg_word_t'(10));
    set_reg(gca_pkg::CFG_MIN_MULT_ACC, cfg_word_t'(30));
    pat = 12'b0100_1101_0010;
    for (int i = 0; i < 12; i++) request_q.push_back(pat[i]);
    wait_idle();

    // zero multiple, zero divisor, zero minimum: whole remainder, not final
    set_reg(gca_pkg::CFG_SIZE_MULTIPLE, cfg_word_t'(0));
    set_reg(gca_pkg::CFG_K_DIVISOR, cfg_word_t'(0));
    set_reg(gca_pkg::CFG_MIN_MULT_CPU, cfg_word_t'(0));
    set_reg(gca_pkg::CFG_MIN_MULT_ACC, cfg_word_t'(0));
    set_reg(gca_pkg::CFG_TOTAL_SIZE, assigned + gca_pkg::SIZE_BITS'(500));
    request_q.push_back(1'b1);
    request_q.push_back(1'b0);
    wait_idle();

    // zero shares: empty package on CPU, minimum package on accelerator
    set_reg(gca_pkg::CFG_CPU_SHARE, cfg_word_t'(0));
    set_reg(gca_pkg::CFG_ACC_SHARE, cfg_word_t'(0));
    set_reg(gca_pkg::CFG_K_DIVISOR, cfg_word_t'(200));
    set_reg(gca_pkg::CFG_MIN_MULT_ACC, cfg_word_t'(3));
    set_reg(gca_pkg::CFG_TOTAL_SIZE, assigned + gca_pkg::SIZE_BITS'(300));
    request_q.push_back(1'b0);
    request_q.push_back(1'b1);
    wait_idle();

    // total lowered below the assigned amount
    set_reg(gca_pkg::CFG_TOTAL_SIZE, assigned >> 1);
    request_q.push_back(1'b1);
    wait_idle();

    sent = 0;
    while (sent < 410) begin
      r = {$urandom, $urandom};
      case ($urandom_range(0, 5))
        0: t = assigned - gca_pkg::SIZE_BITS'(r[9:0]);
        1: t = assigned + gca_pkg::SIZE_BITS'($urandom_range(1, 50));
        2, 3: t = assigned + gca_pkg::SIZE_BITS'($urandom_range(100, 20000));
        4: t = assigned + gca_pkg::SIZE_BITS'(r[31:0]);
        default: t = assigned + gca_pkg::SIZE_BITS'(r[35:0]);
      endcase
      set_reg(gca_pkg::CFG_TOTAL_SIZE, t);
      set_reg(gca_pkg::CFG_SIZE_MULTIPLE, cfg_word_t'(pick_mult(8)));
      set_reg(gca_pkg::CFG_CPU_SHARE, cfg_word_t'(pick_share()));
      set_reg(gca_pkg::CFG_ACC_SHARE, cfg_word_t'(pick_share()));
      case ($urandom_range(0, 9))
        0: set_reg(gca_pkg::CFG_K_DIVISOR, cfg_word_t'(0));
        1, 2: set_reg(gca_pkg::CFG_K_DIVISOR, cfg_word_t'($urandom_range(1, 64)));
        3: set_reg(gca_pkg::CFG_K_DIVISOR, cfg_word_t'(4095));
        default: set_reg(gca_pkg::CFG_K_DIVISOR, cfg_word_t'($urandom_range(65, 4095)));
      endcase
      set_reg(gca_pkg::CFG_MIN_MULT_CPU, cfg_word_t'(pick_mult(6)));
      set_reg(gca_pkg::CFG_MIN_MULT_ACC, cfg_word_t'(pick_mult(6)));
      r[31:0] = $urandom_range(20, 60);
      queue_requests(r[31:0], 25 * $urandom_range(0, 4));
      sent += r[31:0];
      wait_idle();
    end

    // largest total, multiple, shares and minimums with the smallest divisor;
    // the guided package covers the whole remainder and is clipped
    set_reg(gca_pkg::CFG_TOTAL_SIZE, {gca_pkg::SIZE_BITS{1'b1}});
    set_reg(gca_pkg::CFG_SIZE_MULTIPLE, cfg_word_t'(16'hFFFF));
    set_reg(gca_pkg::CFG_CPU_SHARE, cfg_word_t'(65536));
    set_reg(gca_pkg::CFG_ACC_SHARE, cfg_word_t'(65536));
    set_reg(gca_pkg::CFG_K_DIVISOR, cfg_word_t'(1));
    set_reg(gca_pkg::CFG_MIN_MULT_CPU, cfg_word_t'(16'hFFFF));
    set_reg(gca_pkg::CFG_MIN_MULT_ACC, cfg_word_t'(16'hFFFF));
    request_q.push_back(1'b1);
    request_q.push_back(1'b0);
    request_q.push_back(1'b1);
    wait_idle();

    repeat (80) @(posedge clk_i);
    if (grants_q.size() != 0) begin
      $error("%0d expected results never arrived", grants_q.size());
      errors++;
    end
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
